// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CellW = 16;
  localparam int unsigned ColW  = 7;
  localparam int unsigned RowW  = 6;
  localparam int unsigned CurRowW = 5;

  typedef logic [CharW-1:0] char_t;
  typedef logic [CellW-1:0] cell_t;
  typedef logic [ColW-1:0]  col_t;
  typedef logic [RowW-1:0]  row_t;

  typedef enum logic [1:0] {
    OP_PUT_CURSOR = 2'd0,
    OP_PUT_AT     = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ       = 2'd3
  } op_e;

  localparam char_t BLANK      = 8'h20;
  localparam char_t NEWLINE    = 8'h0A;
  localparam char_t TAB        = 8'h09;
  localparam char_t BACKSPACE  = 8'h08;
  localparam char_t RESET_ATTR = 8'h0F;

  // register index 0 sits at byte address 0
  localparam logic REG_ATTR = 1'b0;

endpackage

// ===== rtl/text_console_writer_top.sv =====
`timescale 1ns / 1ps
// put, put-at and read pass through the ST_WR or ST_RD state before done_o; a new start is taken only while busy is low
// clear sweeps every cell to blanks through the single write port of the screen store
// a put that scrolls runs a copy walk, then a blank row fill
// after reset the store is swept to blanks with busy high
// done_o marks each result for one cycle; the receiver cannot stall
module text_console_writer_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  tcw_pkg::op_e       operation_i,
  input  tcw_pkg::char_t     char_code_i,
  input  tcw_pkg::col_t      col_i,
  input  tcw_pkg::row_t      row_i,
  output logic               done_o,
  output logic [6:0]         cursor_col_o,
  output logic [4:0]         cursor_row_o,
  output logic [15:0]        cell_value_o,
  output logic               scrolled_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tcw_pkg::*;

  localparam int unsigned Cells = COLUMNS * ROWS;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam logic [AddrW-1:0] LastAddr  = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0] ColsAddr  = AddrW'(COLUMNS);
  localparam logic [AddrW-1:0] LastRowAd = AddrW'(Cells - COLUMNS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WR   = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_SCRL = 3'd3;
  localparam logic [2:0] ST_SDRN = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;

  logic [2:0]       state_q;
  col_t             col_q;
  row_t             row_q;
  char_t            attr_q;
  logic             done_q;
  logic             scroll_q;
  cell_t            cell_value_q;
  logic             in_range_q;
  logic             wr_en_q;
  logic [AddrW-1:0] wr_addr_q;
  cell_t            wr_data_q;
  logic [AddrW-1:0] src_q;
  logic [AddrW-1:0] dst_q;
  logic             pend_q;
  logic [AddrW-1:0] fill_q;
  cell_t            fill_data_q;
  logic             report_q;
  cell_t            rd_data_q;

  cell_t            mem [Cells];

  // cursor step for a put at the cursor
  logic [7:0]       ncol;
  logic [6:0]       nrow;
  logic             pwr_en;
  char_t            pwr_ch;
  col_t             pwr_col;
  logic             need_scroll;

  col_t             sel_col;
  row_t             sel_row;
  logic [AddrW-1:0] cell_addr;
  logic             in_range;
  logic [AddrW-1:0] rd_addr;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  cell_t            mem_wdata;
  logic             accept;
  logic             cfg_wr;

  assign accept = start && (state_q == ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    ncol        = {1'b0, col_q};
    nrow        = {1'b0, row_q};
    pwr_en      = 1'b0;
    pwr_ch      = char_code_i;
    pwr_col     = col_q;
    need_scroll = 1'b0;
    case (char_code_i)
      NEWLINE: begin
        ncol = 8'd0;
        nrow = {1'b0, row_q} + 7'd1;
      end
      TAB: begin
        ncol = ({1'b0, col_q} + 8'd4) & 8'hFC;
      end
      BACKSPACE: begin
        if (col_q != '0) ncol = {1'b0, col_q} - 8'd1;
        pwr_en  = 1'b1;
        pwr_ch  = BLANK;
        pwr_col = ncol[6:0];
      end
      default: begin
        pwr_en = 1'b1;
        ncol   = {1'b0, col_q} + 8'd1;
      end
    endcase
    if (ncol >= 8'(COLUMNS)) begin
      ncol = 8'd0;
      nrow = nrow + 7'd1;
    end
    if (nrow >= 7'(ROWS)) begin
      nrow        = 7'(ROWS - 1);
      need_scroll = 1'b1;
    end
  end

  assign sel_col   = (operation_i == OP_PUT_CURSOR) ? pwr_col : col_i;
  assign sel_row   = (operation_i == OP_PUT_CURSOR) ? row_q : row_i;
  assign cell_addr = AddrW'(sel_row) * ColsAddr + AddrW'(sel_col);
  assign in_range  = ({1'b0, col_i} < 8'(COLUMNS)) && ({1'b0, row_i} < 7'(ROWS));
  assign rd_addr   = (state_q == ST_IDLE) ? cell_addr : src_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = wr_data_q;
    case (state_q)
      ST_WR: begin
        mem_we = wr_en_q;
      end
      ST_SCRL, ST_SDRN: begin
        mem_we    = pend_q;
        mem_waddr = dst_q;
        mem_wdata = rd_data_q;
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = fill_q;
        mem_wdata = fill_data_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // screen store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_wr && (paddr[2] == REG_ATTR)) begin
      attr_q <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      col_q        <= '0;
      row_q        <= '0;
      done_q       <= 1'b0;
      scroll_q     <= 1'b0;
      cell_value_q <= '0;
      in_range_q   <= 1'b0;
      wr_en_q      <= 1'b0;
      wr_addr_q    <= '0;
      wr_data_q    <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      pend_q       <= 1'b0;
      fill_q       <= '0;
      fill_data_q  <= {RESET_ATTR, BLANK};
      report_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cell_value_q <= '0;
            scroll_q     <= 1'b0;
            wr_addr_q    <= cell_addr;
            case (operation_i)
              OP_PUT_CURSOR: begin
                wr_en_q   <= pwr_en;
                wr_data_q <= {attr_q, pwr_ch};
                col_q     <= ncol[6:0];
                row_q     <= nrow[5:0];
                scroll_q  <= need_scroll;
                state_q   <= ST_WR;
              end
              OP_PUT_AT: begin
                wr_en_q   <= in_range;
                wr_data_q <= {attr_q, char_code_i};
                state_q   <= ST_WR;
              end
              OP_CLEAR: begin
                col_q       <= '0;
                row_q       <= '0;
                fill_q      <= '0;
                fill_data_q <= {attr_q, BLANK};
                report_q    <= 1'b1;
                state_q     <= ST_CLR;
              end
              default: begin
                in_range_q <= in_range;
                state_q    <= ST_RD;
              end
            endcase
          end
        end
        ST_WR: begin
          if (scroll_q) begin
            src_q   <= ColsAddr;
            pend_q  <= 1'b0;
            state_q <= ST_SCRL;
          end else begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_RD: begin
          cell_value_q <= in_range_q ? rd_data_q : '0;
          done_q       <= 1'b1;
          state_q      <= ST_IDLE;
        end
        ST_SCRL: begin
          // read one row down, write the previous beat one row up
          dst_q  <= src_q - ColsAddr;
          pend_q <= 1'b1;
          src_q  <= src_q + 1'b1;
          if (src_q == LastAddr) state_q <= ST_SDRN;
        end
        ST_SDRN: begin
          pend_q      <= 1'b0;
          fill_q      <= LastRowAd;
          fill_data_q <= {attr_q, BLANK};
          report_q    <= 1'b1;
          state_q     <= ST_CLR;
        end
        ST_CLR: begin
          fill_q <= fill_q + 1'b1;
          if (fill_q == LastAddr) begin
            done_q   <= report_q;
            report_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign cursor_col_o = col_q;
  assign cursor_row_o = row_q[CurRowW-1:0];
  assign cell_value_o = cell_value_q;
  assign scrolled_o   = scroll_q;
  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_ATTR) ? {24'd0, attr_q} : 32'd0;

endmodule
